FILE: hdl/dsdo_pkg.sv
// shared constants and types of the dual sine difference oscillator
// no dependencies; every other file refers to it by scoped names
package dsdo_pkg;

  // block sizing
  localparam int CHANNELS    = 2;
  localparam int PHASE_BITS  = 24;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // item fields and register widths
  localparam int STEP_W      = 24;
  localparam int GAIN_W      = 16;
  localparam int SAMPLE_W    = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO       = 2'd3;

  // one classified request, as handed from front to back
  typedef struct packed {
    logic                  live;
    logic                  channel;
    logic [PHASE_BITS-1:0] phase_one;
    logic [PHASE_BITS-1:0] phase_two;
  } entry_t;

endpackage

FILE: hdl/dsdo_if.sv
// valid/ready channel interfaces: input requests, result samples, register writes
// depends on dsdo_pkg for field widths
interface dsdo_in_if;
  logic valid;
  logic ready;
  logic channel_index;

  modport source (output valid, output channel_index, input ready);
  modport sink   (input valid, input channel_index, output ready);
endinterface

interface dsdo_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dsdo_pkg::SAMPLE_W-1:0]    out_sample;
  logic                                    out_channel;

  modport source (output valid, output out_sample, output out_channel, input ready);
  modport sink   (input valid, input out_sample, input out_channel, output ready);
endinterface

interface dsdo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dsdo_pkg::CFG_IDX_W-1:0]    index;
  logic [dsdo_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/dsdo_front.sv
// front end: accepts requests, checks the channel, reads and advances its phases
// depends on dsdo_pkg and dsdo_in_if
module dsdo_front (
  input  logic                           clk,
  input  logic                           rst,
  dsdo_in_if.sink                        in_ch,
  input  logic [dsdo_pkg::STEP_W-1:0]    step_one,
  input  logic [dsdo_pkg::STEP_W-1:0]    step_two,
  input  logic                           q_full,
  output logic                           push,
  output dsdo_pkg::entry_t               entry
);

  logic [dsdo_pkg::PHASE_BITS-1:0] phase_one [dsdo_pkg::CHANNELS];
  logic [dsdo_pkg::PHASE_BITS-1:0] phase_two [dsdo_pkg::CHANNELS];
  logic [dsdo_pkg::CH_W-1:0]       idx;
  logic                            live;

  // classify the request
  assign idx         = dsdo_pkg::CH_W'(in_ch.channel_index);
  assign live        = (int'(in_ch.channel_index) < dsdo_pkg::CHANNELS);
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  // entry for the back end: phases before this request's advance
  always_comb begin
    entry.live      = live;
    entry.channel   = in_ch.channel_index;
    entry.phase_one = live ? phase_one[idx] : '0;
    entry.phase_two = live ? phase_two[idx] : '0;
  end

  // phase accumulators, wrap modulo one turn
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < dsdo_pkg::CHANNELS; c++) begin
        phase_one[c] <= '0;
        phase_two[c] <= '0;
      end
    end else if (push && live) begin
      phase_one[idx] <= phase_one[idx] + dsdo_pkg::PHASE_BITS'(step_one);
      phase_two[idx] <= phase_two[idx] + dsdo_pkg::PHASE_BITS'(step_two);
    end
  end

endmodule

FILE: hdl/dsdo_queue.sv
// short fifo between front and back so each side stalls on its own
// depends on dsdo_pkg
module dsdo_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dsdo_pkg::entry_t push_entry,
  output logic             full,
  output logic             head_valid,
  output dsdo_pkg::entry_t head,
  input  logic             pop
);

  dsdo_pkg::entry_t                mem [dsdo_pkg::QUEUE_DEPTH];
  logic [dsdo_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dsdo_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dsdo_pkg::QCNT_W-1:0]     count;

  assign full       = (count == dsdo_pkg::QCNT_W'(dsdo_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dsdo_pkg::QPTR_W'(dsdo_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dsdo_pkg::QPTR_W'(dsdo_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dsdo_pkg::QCNT_W'(dsdo_pkg::QUEUE_DEPTH))
    else $error("queue fill count past its depth");
`endif

endmodule

FILE: hdl/dsdo_back.sv
// back end: pipelined quarter-sine polynomial for both oscillators, gain
// products, difference with saturation and the output register
// depends on dsdo_pkg and dsdo_out_if
module dsdo_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  dsdo_pkg::entry_t                     head,
  output logic                                 pop,
  input  logic signed [dsdo_pkg::GAIN_W-1:0]   gain_one,
  input  logic signed [dsdo_pkg::GAIN_W-1:0]   gain_two,
  dsdo_out_if.source                           out_ch
);

  localparam int SIN_STAGES = 7;
  localparam int STAGES     = SIN_STAGES + 2;
  localparam int LANES      = 2;
  localparam int SHL        = (dsdo_pkg::PHASE_BITS >= 16) ? 0 : 16 - dsdo_pkg::PHASE_BITS;
  localparam int SHR        = (dsdo_pkg::PHASE_BITS >= 16) ? dsdo_pkg::PHASE_BITS - 16 : 0;
  localparam logic signed [17:0] COEF [4] = '{-18'sd153, 18'sd2611, -18'sd21167, 18'sd51472};
  localparam logic signed [33:0] SAT_HI = 34'sd131071;
  localparam logic signed [33:0] SAT_LO = -34'sd131072;

  // per-oscillator working set; r holds the sine once the last sine stage is done
  typedef struct packed {
    logic [1:0]          quad;
    logic [14:0]         t;
    logic [14:0]         t2;
    logic signed [17:0]  r;
  } lane_t;

  typedef struct packed {
    logic live;
    logic channel;
  } side_t;

  lane_t                               ln     [SIN_STAGES][LANES];
  lane_t                               ln_next[SIN_STAGES][LANES];
  logic signed [32:0]                  prod   [LANES];
  side_t                               sd     [STAGES];
  logic [STAGES-1:0]                   vld;
  logic                                en;
  logic signed [dsdo_pkg::SAMPLE_W-1:0] sample;
  logic signed [dsdo_pkg::SAMPLE_W-1:0] sample_next;

  // quadrant and position from the top 16 bits of the phase
  function automatic lane_t lane_init(input logic [dsdo_pkg::PHASE_BITS-1:0] ph);
    logic [dsdo_pkg::PHASE_BITS+15:0] w;
    logic [15:0]                      a;
    lane_t                            o;
    w      = (dsdo_pkg::PHASE_BITS + 16)'(ph) << SHL;
    a      = w[SHR +: 16];
    o.quad = a[15:14];
    o.t    = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    o.t2   = '0;
    o.r    = '0;
    return o;
  endfunction

  // one polynomial step per stage
  function automatic lane_t lane_step(input int k, input lane_t x);
    logic [29:0]         sq;
    logic signed [33:0]  pr;
    logic signed [33:0]  sv;
    logic signed [17:0]  s;
    lane_t               o;
    o  = x;
    sq = 30'(x.t) * 30'(x.t);
    pr = '0;
    sv = '0;
    s  = '0;
    case (k)
      1: begin
        o.t2 = 15'(sq >> 14);
        o.r  = 18'sd5;
      end
      2, 3, 4, 5: begin
        pr  = 34'(x.r) * 34'(signed'({1'b0, x.t2}));
        o.r = 18'(pr >>> 14) + COEF[k-2];
      end
      6: begin
        pr = 34'(x.r) * 34'(signed'({1'b0, x.t}));
        sv = pr >>> 14;
        if (sv < 0) begin
          s = '0;
        end else if (sv > 34'sd32767) begin
          s = 18'sd32767;
        end else begin
          s = 18'(sv);
        end
        o.r = x.quad[1] ? -s : s;
      end
      default: begin
        o = x;
      end
    endcase
    return o;
  endfunction

  // pipeline moves when the output register is free or being taken
  assign en  = !vld[STAGES-1] || out_ch.ready;
  assign pop = head_valid && en;

  // sine stages for both lanes
  always_comb begin
    ln_next[0][0] = lane_init(head.phase_one);
    ln_next[0][1] = lane_init(head.phase_two);
    for (int k = 1; k < SIN_STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        ln_next[k][l] = lane_step(k, ln[k-1][l]);
      end
    end
  end

  // difference of the scaled sines, saturated
  always_comb begin
    logic signed [33:0] dd;
    logic signed [33:0] sh;
    dd = 34'(prod[1]) - 34'(prod[0]);
    sh = dd >>> 14;
    if (!sd[STAGES-2].live) begin
      sample_next = '0;
    end else if (sh > SAT_HI) begin
      sample_next = SAT_HI[dsdo_pkg::SAMPLE_W-1:0];
    end else if (sh < SAT_LO) begin
      sample_next = SAT_LO[dsdo_pkg::SAMPLE_W-1:0];
    end else begin
      sample_next = dsdo_pkg::SAMPLE_W'(sh);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SIN_STAGES; k++) begin
        for (int l = 0; l < LANES; l++) begin
          ln[k][l] <= ln_next[k][l];
        end
      end
      prod[0] <= 33'(gain_one) * 33'(ln[SIN_STAGES-1][0].r);
      prod[1] <= 33'(gain_two) * 33'(ln[SIN_STAGES-1][1].r);
      sample  <= sample_next;
      sd[0]   <= '{live: head.live, channel: head.channel};
      for (int k = 1; k < STAGES; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], head_valid};
    end
  end

  assign out_ch.valid       = vld[STAGES-1];
  assign out_ch.out_sample  = sample;
  assign out_ch.out_channel = sd[STAGES-1].channel;

`ifndef NO_ASSERTIONS
  a_dead_is_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-1] && !sd[STAGES-1].live) |-> (sample == '0))
    else $error("out-of-range channel gave a nonzero sample");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && sd[0].live) |-> (ln[0][0].t <= 15'd16384 && ln[0][1].t <= 15'd16384))
    else $error("quarter-turn position out of range");
  a_sine_bound: assert property (@(posedge clk) disable iff (rst)
    vld[SIN_STAGES-1] |-> (ln[SIN_STAGES-1][0].r <= 18'sd32767 &&
                           ln[SIN_STAGES-1][0].r >= -18'sd32767 &&
                           ln[SIN_STAGES-1][1].r <= 18'sd32767 &&
                           ln[SIN_STAGES-1][1].r >= -18'sd32767))
    else $error("sine value outside q1.15");
`endif

endmodule

FILE: hdl/dual_sine_difference_oscillator_top.sv
// Dual sine difference oscillator, top level.
// Channels (valid/ready, a transfer happens when both are high):
//   in_ch  : request naming the audio channel whose next sample is produced
//   out_ch : one result per request, the saturated Q3.15 difference of
//            oscillator two and oscillator one, with the channel echoed
//   cfg    : register writes (phase steps, gains); always ready, write
//            only while no request is in flight
// Path: a request taken on in_ch passes the queue register, seven sine
// polynomial stages, one product stage and the output register, which takes
// the difference, before its result shows on out_ch.
// Throughput: one request per cycle while the queue is not full; the nine-stage
// back-end pipeline sets the latency, the phase add in the front sets the rate.
// Reset (rst, synchronous): phases, steps and gains go to zero, pipeline
// and queue empty.
// Receiver stall: the back-end pipeline freezes while the output register
// holds an untaken result; the two-entry queue fills and then in_ch ready
// drops until the receiver takes results again.
// depends on dsdo_pkg, dsdo_if, dsdo_front, dsdo_queue, dsdo_back
module dual_sine_difference_oscillator_top (
  input  logic        clk,
  input  logic        rst,
  dsdo_in_if.sink     in_ch,
  dsdo_out_if.source  out_ch,
  dsdo_cfg_if.sink    cfg
);

  logic [dsdo_pkg::STEP_W-1:0]        step_one;
  logic [dsdo_pkg::STEP_W-1:0]        step_two;
  logic signed [dsdo_pkg::GAIN_W-1:0] gain_one;
  logic signed [dsdo_pkg::GAIN_W-1:0] gain_two;
  logic                               push;
  logic                               q_full;
  logic                               head_valid;
  logic                               pop;
  dsdo_pkg::entry_t                   push_entry;
  dsdo_pkg::entry_t                   head;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_one <= '0;
      step_two <= '0;
      gain_one <= '0;
      gain_two <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        dsdo_pkg::REG_PHASE_STEP_ONE: step_one <= cfg.data[dsdo_pkg::STEP_W-1:0];
        dsdo_pkg::REG_PHASE_STEP_TWO: step_two <= cfg.data[dsdo_pkg::STEP_W-1:0];
        dsdo_pkg::REG_GAIN_ONE:       gain_one <= signed'(cfg.data[dsdo_pkg::GAIN_W-1:0]);
        dsdo_pkg::REG_GAIN_TWO:       gain_two <= signed'(cfg.data[dsdo_pkg::GAIN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // request intake and phase state
  dsdo_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .step_one (step_one),
    .step_two (step_two),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  // decoupling queue
  dsdo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // sine and difference pipeline
  dsdo_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .gain_one   (gain_one),
    .gain_two   (gain_two),
    .out_ch     (out_ch)
  );

endmodule
